### rtl/assert_macros.svh
// Assertion macros used by the RTL of the take-back-half regulator.
// Each macro expects a clock named clk and a synchronous reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define TBHV_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Trigger in one cycle implies the consequence in the following cycle.
`define TBHV_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

### rtl/tbhv_pkg.sv
// Package for the take-back-half velocity regulator: sequencer states,
// register indexes, reset values and field widths. No dependencies.
package tbhv_pkg;

  localparam int DRIVE_FRAC_BITS_DEF = 16;
  localparam int Q16_FRAC            = 16;

  // 60 s/min * 1000 ms/s * 256 (fraction bits of ticks per rev)
  localparam logic [23:0] RPM_SCALE = 24'd15360000;

  localparam logic [16:0] Q16_ONE = 17'd65536;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 18;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_LOOP_GAIN     = 2'd0,
    CFG_TICKS_PER_REV = 2'd1,
    CFG_MAX_POWER     = 2'd2
  } cfg_index_t;

  localparam logic [15:0] LOOP_GAIN_RST     = 16'd3277;
  localparam logic [17:0] TICKS_PER_REV_RST = 18'd18432;
  localparam logic [6:0]  MAX_POWER_RST     = 7'd110;

  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_SET  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_NUM,
    ST_MUL_DEN,
    ST_DIV_CHK,
    ST_DIV,
    ST_RPM,
    ST_ERR_MUL,
    ST_REG_UPD,
    ST_CMD_MUL,
    ST_CMD_FIN
  } state_t;

endpackage

### rtl/take_back_half_velocity_loop.sv
// Take-back-half flywheel velocity regulator, one item at a time.
// A set item goes straight to the command multiply; a tick first runs the rpm multiplies and
// the 16-step restoring divider, which a tick whose rpm is kept or saturated skips.
// No new item is taken until the result is loaded; one shared 33x25 multiplier is used four
// times for a tick, and a stalled result keeps the block busy.
// Reset (rst, synchronous, active high) clears all regulator state and loads the default
// registers: gain 3277, 72 ticks per revolution, max power 110.
`include "assert_macros.svh"

module take_back_half_velocity_loop
  import tbhv_pkg::*;
#(
  parameter int DRIVE_FRAC_BITS = DRIVE_FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // item channel
  input  logic                   item_valid,
  output logic                   item_stall,
  input  logic                   kind,
  input  logic signed [31:0]     encoder_count,
  input  logic        [31:0]     time_ms,
  input  logic signed [13:0]     target_rpm,
  input  logic        [16:0]     drive_hint,
  // result channel
  output logic                   result_valid,
  input  logic                   result_stall,
  output logic signed [7:0]      motor_command,
  output logic signed [15:0]     measured_rpm,
  output logic        [16:0]     drive_level,
  // configuration channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int F          = DRIVE_FRAC_BITS;
  localparam int DW         = F + 1;
  localparam int UP_SHIFT   = (F >= Q16_FRAC) ? F - Q16_FRAC : 0;
  localparam int DOWN_SHIFT = (F < Q16_FRAC) ? Q16_FRAC - F : 0;
  localparam int SW         = 35 + UP_SHIFT;
  localparam int CW         = F + 9;
  localparam int QW         = DW + 8;
  localparam logic [DW-1:0] DRIVE_ONE = DW'(1) << F;

  // configuration
  logic [15:0] loop_gain;
  logic [17:0] ticks_per_rev_q8;
  logic [6:0]  max_power;

  // regulator state
  logic [31:0]        last_count;
  logic [31:0]        last_time;
  logic signed [15:0] current_rpm;
  logic signed [13:0] goal_rpm;
  logic signed [16:0] previous_error;
  logic [DW-1:0]      drive_now;
  logic [DW-1:0]      drive_at_crossing;
  logic [DW-1:0]      drive_guess;
  logic               awaiting_first_cross;

  // sequencer and datapath registers
  state_t             state, state_next;
  logic [31:0]        dms;
  logic [31:0]        mag;
  logic               neg;
  logic               upd_ok;
  logic [55:0]        num;
  logic [49:0]        den;
  logic [49:0]        rem;
  logic [15:0]        low;
  logic [15:0]        quo;
  logic [3:0]         cnt;
  logic signed [16:0] err;

  // shared multiplier, product registered
  logic signed [32:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [57:0] mul_p;

  logic               item_take;
  logic               result_load;

  assign item_stall  = (state != ST_IDLE);
  assign item_take   = item_valid && !item_stall;
  assign cfg_ready   = 1'b1;
  assign result_load = (state == ST_CMD_FIN) && (!result_valid || !result_stall);

  // input-side arithmetic on acceptance
  logic [31:0]        dms_in;
  logic [31:0]        dcu_in;
  logic [16:0]        p_sat;
  logic [QW-1:0]      guess_wide;
  logic signed [16:0] set_err;

  always_comb begin
    dms_in     = time_ms - last_time;
    dcu_in     = encoder_count - last_count;
    p_sat      = (drive_hint > Q16_ONE) ? Q16_ONE : drive_hint;
    guess_wide = (QW'(p_sat) << UP_SHIFT) >> DOWN_SHIFT;
    set_err    = 17'(target_rpm) - 17'(current_rpm);
  end

  // multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_MUL_NUM: begin
        mul_a = $signed({1'b0, mag});
        mul_b = $signed({1'b0, RPM_SCALE});
      end
      ST_MUL_DEN: begin
        mul_a = $signed({1'b0, dms});
        mul_b = $signed({7'd0, ticks_per_rev_q8});
      end
      ST_ERR_MUL: begin
        mul_a = 33'(goal_rpm - current_rpm);
        mul_b = $signed({9'd0, loop_gain});
      end
      ST_CMD_MUL, ST_CMD_FIN: begin
        mul_a = $signed(33'(drive_now));
        mul_b = $signed({18'd0, max_power});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
  end

  // divider step
  logic [50:0] div_trial;
  logic        div_fit;
  logic        div_ovf;

  always_comb begin
    div_trial = {rem, low[15]};
    div_fit   = div_trial >= {1'b0, den};
    div_ovf   = {10'd0, num[55:16]} >= mul_p[49:0];
  end

  // rpm from quotient, truncated towards zero and saturated
  logic signed [15:0] rpm_q;

  always_comb begin
    if (neg) begin
      rpm_q = quo[15] ? 16'sh8000 : $signed(16'd0 - quo);
    end else begin
      rpm_q = quo[15] ? 16'sh7fff : $signed(quo);
    end
  end

  // drive integration and take-back-half
  logic signed [SW-1:0] scaled;
  logic signed [SW-1:0] d_sum;
  logic [DW-1:0]        d_clamp;
  logic [DW:0]          d_half;
  logic                 sign_flip;
  logic [DW-1:0]        d_new;

  always_comb begin
    scaled  = (SW'($signed(mul_p[32:0])) <<< UP_SHIFT) >>> DOWN_SHIFT;
    d_sum   = scaled + $signed(SW'(drive_now));
    if (d_sum < 0) begin
      d_clamp = '0;
    end else if (d_sum > $signed(SW'(DRIVE_ONE))) begin
      d_clamp = DRIVE_ONE;
    end else begin
      d_clamp = DW'(d_sum);
    end
    d_half    = ({1'b0, d_clamp} + {1'b0, drive_at_crossing}) >> 1;
    // A move to or from zero error counts as a sign change.
    sign_flip = ((err == 0) != (previous_error == 0)) ||
                ((err != 0) && (err[16] != previous_error[16]));
    if (!sign_flip) begin
      d_new = d_clamp;
    end else if (awaiting_first_cross) begin
      d_new = drive_guess;
    end else begin
      d_new = DW'(d_half);
    end
  end

  // motor command and reported drive
  logic [CW-1:0] cmd_sum;
  logic [8:0]    cmd_full;
  logic [QW-1:0] level_wide;

  always_comb begin
    cmd_sum    = CW'(mul_p[F+7:0]) + (CW'(1) << (F - 1));
    cmd_full   = 9'(cmd_sum >> F);
    level_wide = (QW'(drive_now) << DOWN_SHIFT) >> UP_SHIFT;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (item_take) begin
          state_next = (kind == KIND_SET) ? ST_CMD_MUL : ST_MUL_NUM;
        end
      end
      ST_MUL_NUM: state_next = ST_MUL_DEN;
      ST_MUL_DEN: state_next = ST_DIV_CHK;
      ST_DIV_CHK: begin
        if (!upd_ok) begin
          state_next = ST_ERR_MUL;
        end else if (div_ovf) begin
          state_next = ST_ERR_MUL;
        end else begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (cnt == 4'd15) begin
          state_next = ST_RPM;
        end
      end
      ST_RPM:     state_next = ST_ERR_MUL;
      ST_ERR_MUL: state_next = ST_REG_UPD;
      ST_REG_UPD: state_next = ST_CMD_MUL;
      ST_CMD_MUL: state_next = ST_CMD_FIN;
      ST_CMD_FIN: begin
        if (result_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      loop_gain        <= LOOP_GAIN_RST;
      ticks_per_rev_q8 <= TICKS_PER_REV_RST;
      max_power        <= MAX_POWER_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LOOP_GAIN:     loop_gain        <= cfg_data[15:0];
        CFG_TICKS_PER_REV: ticks_per_rev_q8 <= cfg_data[17:0];
        CFG_MAX_POWER:     max_power        <= cfg_data[6:0];
        default: begin
        end
      endcase
    end
  end

  // regulator state
  always_ff @(posedge clk) begin
    if (rst) begin
      last_count           <= '0;
      last_time            <= '0;
      current_rpm          <= '0;
      goal_rpm             <= '0;
      previous_error       <= '0;
      drive_now            <= '0;
      drive_at_crossing    <= '0;
      drive_guess          <= '0;
      awaiting_first_cross <= 1'b0;
    end else begin
      if (item_take) begin
        if (kind == KIND_SET) begin
          goal_rpm             <= target_rpm;
          previous_error       <= set_err;
          drive_guess          <= DW'(guess_wide);
          awaiting_first_cross <= 1'b1;
          drive_at_crossing    <= '0;
        end else begin
          last_count <= encoder_count;
          last_time  <= time_ms;
        end
      end
      if (state == ST_DIV_CHK && upd_ok && div_ovf) begin
        current_rpm <= neg ? 16'sh8000 : 16'sh7fff;
      end
      if (state == ST_RPM) begin
        current_rpm <= rpm_q;
      end
      if (state == ST_REG_UPD) begin
        drive_now      <= d_new;
        previous_error <= err;
        if (sign_flip) begin
          drive_at_crossing    <= d_new;
          awaiting_first_cross <= 1'b0;
        end
      end
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    if (item_take) begin
      dms    <= dms_in;
      neg    <= dcu_in[31];
      mag    <= dcu_in[31] ? 32'd0 - dcu_in : dcu_in;
      upd_ok <= (dms_in != 32'd0) && (ticks_per_rev_q8 != 18'd0);
    end
    if (state == ST_MUL_DEN) begin
      num <= mul_p[55:0];
    end
    if (state == ST_DIV_CHK) begin
      den <= mul_p[49:0];
      rem <= {10'd0, num[55:16]};
      low <= num[15:0];
      cnt <= '0;
    end
    if (state == ST_DIV) begin
      rem <= div_fit ? 50'(div_trial - {1'b0, den}) : div_trial[49:0];
      low <= {low[14:0], 1'b0};
      quo <= {quo[14:0], div_fit};
      cnt <= cnt + 4'd1;
    end
    if (state == ST_ERR_MUL) begin
      err <= 17'(goal_rpm - current_rpm);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (result_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      motor_command <= (cmd_full > 9'd127) ? 8'sd127 : $signed(cmd_full[7:0]);
      measured_rpm  <= current_rpm;
      drive_level   <= 17'(level_wide);
    end
  end

  `TBHV_ASSERT(a_drive_bound, drive_now <= DRIVE_ONE, "drive above full scale")
  `TBHV_ASSERT(a_cross_bound, drive_at_crossing <= DRIVE_ONE, "crossing drive above full scale")
  `TBHV_ASSERT(a_cmd_nonneg, !result_valid || !motor_command[7], "negative motor command")
  `TBHV_ASSERT_NEXT(a_busy_after_take, item_take, state != ST_IDLE, "idle after item transfer")
  `TBHV_ASSERT_NEXT(a_result_shown, result_load, result_valid, "loaded result not shown")

endmodule

### sim/tb_take_back_half_velocity_loop.sv
`timescale 1ns / 1ps
// Self-checking testbench for the take-back-half flywheel velocity regulator.
// Depends on tbhv_pkg and take_back_half_velocity_loop; predicts every result in-line.

module tb_take_back_half_velocity_loop;
  import tbhv_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 62;

  typedef struct {
    logic signed [7:0]  cmd;
    logic signed [15:0] rpm;
    logic        [16:0] drive;
  } reading_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   item_valid = 1'b0;
  logic                   item_stall;
  logic                   kind = KIND_TICK;
  logic signed [31:0]     encoder_count = '0;
  logic        [31:0]     time_ms = '0;
  logic signed [13:0]     target_rpm = '0;
  logic        [16:0]     drive_hint = '0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  logic signed [7:0]      motor_command;
  logic signed [15:0]     measured_rpm;
  logic        [16:0]     drive_level;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // Register copies as the block should hold them.
  logic [15:0] gain_cfg  = LOOP_GAIN_RST;
  logic [17:0] tpr_cfg   = TICKS_PER_REV_RST;
  logic [6:0]  power_cfg = MAX_POWER_RST;

  // Regulator state as the block should hold it; drive values are Q.16.
  logic [31:0] seen_count = '0;
  logic [31:0] seen_time = '0;
  int          rpm_est = 0;
  int          goal_est = 0;
  int          err_last = 0;
  longint      drive_est = 0;
  longint      drive_cross_est = 0;
  longint      guess_est = 0;
  bit          first_cross_pending = 1'b0;

  reading_t expected_readings[$];

  // Stimulus-side view of the flywheel.
  logic [31:0] enc_pos = '0;
  logic [31:0] clock_ms = '0;
  int          goal_tb = 0;

  int  items_sent = 0, set_items = 0, tick_items = 0, results_checked = 0;
  int  settings_used = 0, fail_count = 0, reported = 0, cycle_count = 0, stall_hold = 0;
  bit  tx_steady = 1'b0, rx_steady = 1'b0;

  take_back_half_velocity_loop dut (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (item_valid),
    .item_stall      (item_stall),
    .kind            (kind),
    .encoder_count   (encoder_count),
    .time_ms         (time_ms),
    .target_rpm      (target_rpm),
    .drive_hint      (drive_hint),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .motor_command   (motor_command),
    .measured_rpm    (measured_rpm),
    .drive_level     (drive_level),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_readings.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // Mostly short idle runs, now and then a long one.
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic int sign_of(input longint v);
    if (v > 0) return 1;
    if (v < 0) return -1;
    return 0;
  endfunction

  // Advances the expected regulator state by one item and returns its reading.
  function automatic reading_t step_regulator(input logic k, input logic [31:0] cnt,
      input logic [31:0] t, input logic signed [13:0] tgt, input logic [16:0] pd);
    logic [31:0]     dms, dcu, mag;
    longint unsigned quo;
    longint          err, d, gain_l, power_l, cmd;
    reading_t        r;
    gain_l  = gain_cfg;
    power_l = power_cfg;
    if (k == KIND_SET) begin
      goal_est = tgt;
      err_last = goal_est - rpm_est;
      if (pd > Q16_ONE) guess_est = Q16_ONE;
      else guess_est = pd;
      first_cross_pending = 1'b1;
      drive_cross_est = 0;
    end else begin
      dms = t - seen_time;
      dcu = cnt - seen_count;
      mag = dcu[31] ? 32'd0 - dcu : dcu;
      seen_time  = t;
      seen_count = cnt;
      // A zero interval or a zero divisor leaves the previous speed in place.
      if (dms != 0 && tpr_cfg != 0) begin
        quo = (longint'(mag) * longint'(RPM_SCALE)) / (longint'(dms) * longint'(tpr_cfg));
        if (dcu[31]) rpm_est = (quo >= 32768) ? -32768 : -int'(quo);
        else rpm_est = (quo > 32767) ? 32767 : int'(quo);
      end
      err = goal_est - rpm_est;
      d = drive_est + err * gain_l;
      if (d > longint'(Q16_ONE)) d = longint'(Q16_ONE);
      if (d < 0) d = 0;
      if (sign_of(err) != sign_of(err_last)) begin
        if (first_cross_pending) begin
          d = guess_est;
          first_cross_pending = 1'b0;
        end else begin
          d = (d + drive_cross_est) / 2;
        end
        drive_cross_est = d;
      end
      drive_est = d;
      err_last  = err;
    end
    cmd = (drive_est * power_l + 32768) >>> 16;
    if (cmd > 127) cmd = 127;
    r.cmd   = cmd[7:0];
    r.rpm   = rpm_est[15:0];
    r.drive = drive_est[16:0];
    return r;
  endfunction

  function automatic void check_field(input string what, input integer got,
                                      input integer want);
    if (got !== want) begin
      fail_count++;
      if (reported < 10) begin
        $display("Result %0d: %s is %0d, expected %0d", results_checked, what, got, want);
        reported++;
      end
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      stall_hold = 0;
    end else if (stall_hold > 0) begin
      stall_hold--;
    end else if (rx_steady) begin
      result_stall <= 1'b0;
    end else begin
      result_stall <= ($urandom_range(0, 2) == 0);
      stall_hold = idle_length();
    end
  end

  always @(posedge clk) begin
    reading_t want;
    if (!rst && result_valid && !result_stall) begin
      results_checked++;
      if (expected_readings.size() == 0) begin
        fail_count++;
        if (reported < 10) begin
          $display("Result %0d arrived with nothing outstanding", results_checked);
          reported++;
        end
      end else begin
        want = expected_readings.pop_front();
        check_field("motor_command", motor_command, want.cmd);
        check_field("measured_rpm", measured_rpm, want.rpm);
        check_field("drive_level", drive_level, want.drive);
      end
    end
  end

  task automatic send_item(input logic k, input logic [31:0] cnt, input logic [31:0] t,
                           input logic signed [13:0] tgt, input logic [16:0] pd);
    int gap;
    gap = tx_steady ? 0 : idle_length();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid      <= 1'b1;
    kind            <= k;
    encoder_count   <= cnt;
    time_ms         <= t;
    target_rpm      <= tgt;
    drive_hint      <= pd;
    do @(posedge clk); while (item_stall);
    expected_readings.push_back(step_regulator(k, cnt, t, tgt, pd));
    items_sent++;
    if (k == KIND_SET) set_items++;
    else tick_items++;
  endtask

  task automatic send_tick(input logic [31:0] dc, input logic [31:0] dms);
    enc_pos  = enc_pos + dc;
    clock_ms = clock_ms + dms;
    send_item(KIND_TICK, enc_pos, clock_ms, 14'($urandom), 17'($urandom));
  endtask

  task automatic send_set(input logic signed [13:0] tgt, input logic [16:0] pd);
    goal_tb = tgt;
    send_item(KIND_SET, $urandom, $urandom, tgt, pd);
  endtask

  // Holds the sender back until every outstanding result has been transferred.
  task automatic drain_results();
    item_valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_LOOP_GAIN:     gain_cfg  = val[15:0];
      CFG_TICKS_PER_REV: tpr_cfg   = val[17:0];
      CFG_MAX_POWER:     power_cfg = val[6:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [15:0] gain, input logic [17:0] tpr,
                                input logic [6:0] power);
    drain_results();
    write_reg(CFG_LOOP_GAIN, CFG_DATA_W'(gain));
    write_reg(CFG_TICKS_PER_REV, tpr);
    write_reg(CFG_MAX_POWER, CFG_DATA_W'(power));
    settings_used++;
  endtask

  task automatic test_reset_state();
    send_set(0, 0);
    // Time has not moved since reset for the first two ticks, so the speed must stay at zero.
    send_tick(0, 0);
    send_tick(5, 0);
    send_tick(90, 25);
    send_set(8191, 17'h1FFFF);
  endtask

  // With one tick per revolution and one-minute intervals the speed equals the count step.
  task automatic test_crossings();
    apply_settings(16'd3277, 18'd256, 7'd127);
    send_set(100, 17'd40000);
    send_tick(10, 60000);
    send_tick(200, 60000);
    send_tick(50, 60000);
    send_tick(100, 60000);
    send_tick(100, 60000);
    send_tick(150, 60000);
    send_tick(20, 60000);
    send_tick(100, 60000);
  endtask

  task automatic test_count_extremes();
    send_tick(32'h8000_0000, 60000);
    send_tick(32'h7FFF_FFFF, 60000);
    send_tick(32'hFFFF_FFFF, 1);
    send_set(-8192, 17'd65536);
  endtask

  task automatic test_time_and_divisor_edges();
    send_tick(7, 32'hFFFF_FFF0 - clock_ms);
    send_tick(7, 32);
    apply_settings(16'd3277, 18'd0, 7'd110);
    send_tick(50, 25);
    apply_settings(16'd0, 18'd262143, 7'd0);
    send_tick(1000, 25);
    apply_settings(16'd65535, 18'd262143, 7'd127);
    send_tick(20, 25);
  endtask

  // Each phase runs a target step with a speed wandering around the goal, plus noise.
  task automatic test_random_phases();
    logic [15:0] gain;
    logic [17:0] tpr;
    logic [6:0]  power;
    logic [31:0] dms, cnt, t;
    logic        k;
    int          r, spread, rpm_sim;
    longint      dc;
    for (int p = 0; p < PHASES; p++) begin
      if (p == 1) gain = 16'd0;
      else if (p == 2) gain = 16'd65535;
      else if ($urandom_range(0, 1) == 0) gain = 16'($urandom_range(200, 6000));
      else gain = 16'($urandom_range(0, 65535));
      if (p == 3) tpr = 18'd256;
      else if (p == 4) tpr = 18'd262143;
      else if ($urandom_range(0, 3) == 0) tpr = 18'($urandom_range(256, 262143));
      else tpr = 18'($urandom_range(4608, 36864));
      if (p == 5) power = 7'd0;
      else if (p == 6) power = 7'd127;
      else power = 7'($urandom_range(0, 127));
      apply_settings(gain, tpr, power);
      tx_steady = (p == 7);
      rx_steady = (p == 7);
      enc_pos  = $urandom;
      clock_ms = $urandom;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        r = $urandom_range(0, 99);
        if (i == PHASE_ITEMS / 2 && p % 2 == 1) drain_results();
        if (i == 0 || r < 4) begin
          r = $urandom_range(0, 99);
          send_set((r < 75) ? 14'($urandom_range(200, 6000)) : 14'($urandom),
                   (r < 60) ? 17'($urandom_range(0, 65536)) :
                   (r < 85) ? 17'd65536 : 17'($urandom_range(65537, 131071)));
        end else if (r < 12) begin
          k   = 1'($urandom_range(0, 1));
          cnt = $urandom;
          t   = $urandom;
          if (k == KIND_TICK) begin
            enc_pos  = cnt;
            clock_ms = t;
          end
          send_item(k, cnt, t, 14'($urandom), 17'($urandom));
        end else begin
          r = $urandom_range(0, 99);
          if (r < 4) dms = 0;
          else if (r < 8) dms = 1;
          else if (r < 12) dms = $urandom_range(100, 100000);
          else dms = $urandom_range(20, 30);
          spread  = (goal_tb < 0 ? -goal_tb : goal_tb) / 4 + 20;
          rpm_sim = goal_tb + int'($urandom_range(0, 2 * spread)) - spread;
          dc = (longint'(rpm_sim) * longint'(tpr_cfg) * longint'(dms)) / 15360000;
          dc = dc + int'($urandom_range(0, 2)) - 1;
          send_tick(32'(dc), dms);
        end
      end
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_crossings();
    test_count_extremes();
    test_time_and_divisor_edges();
    test_random_phases();
    item_valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    fail_count += expected_readings.size();
    $display("Sent %0d items (%0d target changes, %0d samples) under %0d register settings;",
             items_sent, set_items, tick_items, settings_used);
    $display("checked %0d results field by field, %0d faults found.", results_checked,
             fail_count);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
